>>> rtl/mptm_pkg.sv
// Shared types and constants for the multi-pattern text masker.
// No dependencies; every other file in rtl/ imports this package.
package mptm_pkg;

  localparam int unsigned PATTERN_W   = 64;
  localparam int unsigned LENGTHS_W   = 16;
  localparam int unsigned LEN_FIELD_W = 4;
  localparam int unsigned NUM_SLOTS   = 4;
  localparam int unsigned CFG_IDX_W   = 3;

  localparam logic [7:0] MASK_CHAR = 8'h2A;  // '*'
  localparam logic [7:0] WILD_CHAR = 8'h0A;  // newline matches any byte

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATTERN_A = 3'd0,
    REG_PATTERN_B = 3'd1,
    REG_PATTERN_C = 3'd2,
    REG_PATTERN_D = 3'd3,
    REG_LENGTHS   = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       chunk_end;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
  } out_t;

  // Byte moving between stages, with its end-of-chunk flag.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } stage_word_t;

endpackage

>>> rtl/mptm_cfg.sv
// Configuration registers of the text masker: four patterns and the packed lengths.
// Depends on mptm_pkg.
module mptm_cfg #(
  parameter int unsigned MAX_LEN = 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [mptm_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [mptm_pkg::PATTERN_W-1:0]      cfg_data_i,
  output logic [mptm_pkg::PATTERN_W-1:0]      pat_o [mptm_pkg::NUM_SLOTS],
  output logic [$clog2(MAX_LEN+1)-1:0]        len_o [mptm_pkg::NUM_SLOTS]
);
  import mptm_pkg::*;

  localparam int unsigned LW = $clog2(MAX_LEN + 1);

  logic [PATTERN_W-1:0] pat_q [NUM_SLOTS];
  logic [PATTERN_W-1:0] pat_d [NUM_SLOTS];
  logic [LENGTHS_W-1:0] lens_q, lens_d;
  logic                 wr_en;

  assign cfg_ready_o = 1'b1;
  assign wr_en       = cfg_valid_i && cfg_ready_o;

  always_comb begin
    pat_d  = pat_q;
    lens_d = lens_q;
    if (wr_en) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_PATTERN_A: pat_d[0] = cfg_data_i;
        REG_PATTERN_B: pat_d[1] = cfg_data_i;
        REG_PATTERN_C: pat_d[2] = cfg_data_i;
        REG_PATTERN_D: pat_d[3] = cfg_data_i;
        REG_LENGTHS:   lens_d   = cfg_data_i[LENGTHS_W-1:0];
        default:       ;  // drop writes beyond the register list
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int p = 0; p < NUM_SLOTS; p++) begin
        pat_q[p] <= '0;
      end
      lens_q <= '0;
    end else begin
      pat_q  <= pat_d;
      lens_q <= lens_d;
    end
  end

  // Clamp each length nibble to the window depth.
  always_comb begin
    for (int p = 0; p < NUM_SLOTS; p++) begin
      pat_o[p] = pat_q[p];
      if (lens_q[LEN_FIELD_W*p +: LEN_FIELD_W] > LEN_FIELD_W'(MAX_LEN)) begin
        len_o[p] = LW'(MAX_LEN);
      end else begin
        len_o[p] = lens_q[LEN_FIELD_W*p +: LW];
      end
    end
  end

endmodule

>>> rtl/mptm_stage.sv
// One masking stage: a window of held bytes, a parallel pattern compare and mask.
// Depends on mptm_pkg.
module mptm_stage #(
  parameter int unsigned MAX_LEN = 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic [mptm_pkg::PATTERN_W-1:0]  pat_i,
  input  logic [$clog2(MAX_LEN+1)-1:0]    len_i,
  input  logic                            in_valid_i,
  input  mptm_pkg::stage_word_t           in_word_i,
  output logic                            in_ready_o,
  output logic                            out_valid_o,
  output mptm_pkg::stage_word_t           out_word_o,
  input  logic                            out_ready_i
);
  import mptm_pkg::*;

  localparam int unsigned LW = $clog2(MAX_LEN + 1);

  logic [7:0]    win_q  [MAX_LEN];
  logic [7:0]    win_d  [MAX_LEN];
  logic [7:0]    masked [MAX_LEN];
  logic [LW-1:0] fill_q, fill_d, fill_after, keep;
  logic          busy_q, busy_d, flush_q, flush_d;
  logic          tested, match, hit, emit_fire, in_fire, work_after;

  assign keep = (len_i == '0) ? '0 : len_i - LW'(1);

  // Compare the oldest len_i held bytes against the pattern.
  always_comb begin
    match = 1'b1;
    for (int j = 0; j < MAX_LEN; j++) begin
      if (LW'(j) < len_i) begin
        if (pat_i[8*j +: 8] != WILD_CHAR && win_q[j] != pat_i[8*j +: 8]) begin
          match = 1'b0;
        end
      end
    end
  end

  // A push leaves emissions pending while more than len-1 bytes are held.
  assign tested = busy_q && (fill_q > keep);
  assign hit    = tested && (len_i != '0) && match;

  always_comb begin
    for (int j = 0; j < MAX_LEN; j++) begin
      if (hit && LW'(j) < len_i && pat_i[8*j +: 8] != WILD_CHAR) begin
        masked[j] = MASK_CHAR;
      end else begin
        masked[j] = win_q[j];
      end
    end
  end

  assign out_valid_o     = tested || (flush_q && fill_q != '0);
  assign out_word_o.data = masked[0];
  assign out_word_o.last = flush_q && (fill_q == LW'(1));

  assign emit_fire  = out_valid_o && out_ready_i;
  assign fill_after = emit_fire ? fill_q - LW'(1) : fill_q;
  assign work_after = (busy_q && fill_after > keep) || (flush_q && fill_after != '0);
  assign in_ready_o = !work_after;
  assign in_fire    = in_valid_i && in_ready_o;

  // Shift out the oldest byte (with masks applied), then append the new one.
  always_comb begin
    win_d = win_q;
    if (emit_fire) begin
      for (int j = 0; j < MAX_LEN - 1; j++) begin
        win_d[j] = masked[j+1];
      end
      win_d[MAX_LEN-1] = '0;
    end
    if (in_fire) begin
      for (int j = 0; j < MAX_LEN; j++) begin
        if (fill_after == LW'(j)) begin
          win_d[j] = in_word_i.data;
        end
      end
    end
  end

  assign fill_d  = in_fire ? fill_after + LW'(1) : fill_after;
  assign busy_d  = in_fire ? (fill_d > keep) : (busy_q && fill_after > keep);
  assign flush_d = (in_fire && in_word_i.last) ? 1'b1 : (flush_q && fill_after != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q  <= '0;
      busy_q  <= 1'b0;
      flush_q <= 1'b0;
    end else begin
      fill_q  <= fill_d;
      busy_q  <= busy_d;
      flush_q <= flush_d;
    end
  end

  always_ff @(posedge clk_i) begin
    win_q <= win_d;
  end

`ifndef SYNTH
  a_fill_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= LW'(MAX_LEN))
    else $error("stage window overfilled");

  a_flush_has_bytes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    flush_q |-> fill_q != '0)
    else $error("flush pending on an empty window");

  a_out_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_word_o))
    else $error("stage output changed while held");
`endif

endmodule

>>> rtl/multi_pattern_text_masker.sv
// Top level of the multi-pattern text masker: input register, stage chain, output register.
// Depends on mptm_pkg, mptm_cfg and mptm_stage.
//
// Usage: text enters one byte per word on the in channel (in_valid_i / in_stall_o),
// chunk_end set on the last byte of a chunk. Masked bytes leave on the out channel
// (out_valid_o / out_stall_i) in the same order, out_last set on the chunk's final byte.
// Patterns and lengths are to be written through the cfg channel while no chunk is in
// flight; the block itself does not enforce this. Each pattern stage holds back len-1
// bytes. A byte passes from the input register through each stage's window to the
// output register once the word that completes its last window is taken in.
// Throughput: one byte per cycle inside a chunk while the receiver does not stall.
// A chunk end drains every window, one byte per cycle when not stalled, stage after
// stage; the next chunk backs up behind the drain, so the input stalls while it runs.
// A stalled receiver holds the output register; stall then backs up stage by stage
// to in_stall_o without losing a byte.
// Reset clears all patterns and lengths (every stage passes bytes straight through)
// and empties all windows; payload registers are not reset.
module multi_pattern_text_masker #(
  parameter int unsigned NUM_PATTERNS    = 4,
  parameter int unsigned MAX_PATTERN_LEN = 8
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  mptm_pkg::in_t                    in_word_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output mptm_pkg::out_t                   out_word_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [mptm_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [mptm_pkg::PATTERN_W-1:0]   cfg_data_i
);
  import mptm_pkg::*;

  localparam int unsigned LW = $clog2(MAX_PATTERN_LEN + 1);

  logic [PATTERN_W-1:0] pat [NUM_SLOTS];
  logic [LW-1:0]        len [NUM_SLOTS];

  // Lane p feeds stage p; lane NUM_PATTERNS feeds the output register.
  logic        lane_valid [NUM_PATTERNS+1];
  logic        lane_ready [NUM_PATTERNS+1];
  stage_word_t lane_word  [NUM_PATTERNS+1];

  logic in_full_q, in_full_d, in_accept;
  in_t  in_q;
  logic out_valid_q, out_valid_d, out_load;
  out_t out_q;

  mptm_cfg #(
    .MAX_LEN (MAX_PATTERN_LEN)
  ) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .pat_o       (pat),
    .len_o       (len)
  );

  // Input register: hold the word until stage 0 takes it.
  assign in_stall_o = in_full_q && !lane_ready[0];
  assign in_accept  = in_valid_i && !in_stall_o;
  assign in_full_d  = in_accept || (in_full_q && !lane_ready[0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_full_q <= 1'b0;
    end else begin
      in_full_q <= in_full_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_q <= in_word_i;
    end
  end

  assign lane_valid[0]     = in_full_q;
  assign lane_word[0].data = in_q.text_byte;
  assign lane_word[0].last = in_q.chunk_end;

  // Pattern stages in order: each one scans what the earlier ones produced.
  for (genvar p = 0; p < NUM_PATTERNS; p++) begin : g_stage
    mptm_stage #(
      .MAX_LEN (MAX_PATTERN_LEN)
    ) u_stage (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .pat_i       (pat[p]),
      .len_i       (len[p]),
      .in_valid_i  (lane_valid[p]),
      .in_word_i   (lane_word[p]),
      .in_ready_o  (lane_ready[p]),
      .out_valid_o (lane_valid[p+1]),
      .out_word_o  (lane_word[p+1]),
      .out_ready_i (lane_ready[p+1])
    );
  end

  // Output register: load when empty or when the receiver takes the current word.
  assign out_load                 = !out_valid_q || !out_stall_i;
  assign lane_ready[NUM_PATTERNS] = out_load;
  assign out_valid_d              = out_load ? lane_valid[NUM_PATTERNS] : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load && lane_valid[NUM_PATTERNS]) begin
      out_q.out_byte <= lane_word[NUM_PATTERNS].data;
      out_q.out_last <= lane_word[NUM_PATTERNS].last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

>>> tb/multi_pattern_text_masker_test.sv
// Self-checking testbench for multi_pattern_text_masker: directed table, then random chunks.
// Depends on mptm_pkg and the RTL top level; holds its own model of the masking chain.
module multi_pattern_text_masker_test;
  timeunit 1ns;
  timeprecision 1ps;

  import mptm_pkg::*;

  localparam int unsigned MAX_LEN      = 8;
  localparam int unsigned MAX_RESULTS  = 29;
  localparam int unsigned RANDOM_ITEMS = 300;
  localparam int unsigned SETTLE       = 40;      // idle clocks after the last owed word so the pipeline settles
  localparam int unsigned LONG_HOLD    = 150;
  localparam int unsigned RUN_LIMIT    = 200000;
  localparam int unsigned HOLD_PHASE   = 4;
  localparam int unsigned PLAN_ROWS    = 26;
  localparam int          FIRST_UNUSED_REG = int'(REG_LENGTHS) + 1;

  // Kinds of pattern setting used by the random phases.
  localparam int SET_ALL_ONES  = 1;   // every pattern byte 8'hFF, every length 8
  localparam int SET_ZERO_LONG = 2;   // zero bytes, nibbles 15 (clamped to 8)
  localparam int SET_EMPTY     = 3;   // every length zero: plain pass-through

  localparam logic ROW_TEXT = 1'b0;
  localparam logic ROW_CFG  = 1'b1;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_stall_o;
  in_t                  in_word_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  out_t                 out_word_o;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [PATTERN_W-1:0] cfg_data_i;

  multi_pattern_text_masker i_dut (.*);

  // Directed table: a config row writes one register, a text row sends one word.
  // Rows marked typed carry the expected byte directly (patterns still empty).
  typedef struct packed {
    logic        is_cfg;
    cfg_reg_e    reg_sel;
    logic [63:0] value;
    logic [7:0]  text;
    logic        last;
    logic        typed;
    logic [7:0]  want;
  } plan_row_t;

  plan_row_t plan_tbl [PLAN_ROWS] = '{
    // after reset every stage is empty: bytes come straight back
    '{ROW_TEXT, REG_PATTERN_A, 64'h0, 8'h00, 1'b0, 1'b1, 8'h00},
    '{ROW_TEXT, REG_PATTERN_A, 64'h0, 8'hFF, 1'b1, 1'b1, 8'hFF},
    // a = "bad", b = "a?c" with a newline wildcard, c = two zero bytes, d = "zzzzzzzz"
    '{ROW_CFG,  REG_PATTERN_A, 64'h0000_0000_0064_6162, 8'h00, 1'b0, 1'b0, 8'h00},
    '{ROW_CFG,  REG_PATTERN_B, 64'h0000_0000_0063_0A61, 8'h00, 1'b0, 1'b0, 8'h00},
    '{ROW_CFG,  REG_PATTERN_C, 64'h0000_0000_0000_0000, 8'h00, 1'b0, 1'b0, 8'h00},
    '{ROW_CFG,  REG_PATTERN_D, 64'h7A7A_7A7A_7A7A_7A7A, 8'h00, 1'b0, 1'b0, 8'h00},
    // lengths: a=3, b=3, c=2, d=15 which counts as 8
    '{ROW_CFG,  REG_LENGTHS,   64'h0000_0000_0000_F233, 8'h00, 1'b0, 1'b0, 8'h00},
    // "bada" + "qc": stage a stars "bad", stage b then stars "a" and "c" but keeps "q"
    '{ROW_TEXT, REG_PATTERN_A, 64'h0, 8'h62, 1'b0, 1'b0, 8'h00},
    '{ROW_TEXT, REG_PATTERN_A, 64'h0, 8'h61, 1'b0, 1'b0, 8'h00},
    '{ROW_TEXT, REG_PATTERN_A, 64'h0, 8'h64, 1'b0, 1'b0, 8'h00},
    '{ROW_TEXT, REG_PATTERN_A, 64'h0, 8'h61, 1'b0, 1'b0, 8'h00},
    '{ROW_TEXT, REG_PATTERN_A, 64'h0, 8'h71, 1'b0, 1'b0, 8'h00},
    '{ROW_TEXT, REG_PATTERN_A, 64'h0, 8'h63, 1'b0, 1'b0, 8'h00},
    // zero pattern bytes must match zero text bytes exactly
    '{ROW_TEXT, REG_PATTERN_A, 64'h0, 8'h00, 1'b0, 1'b0, 8'h00},
    '{ROW_TEXT, REG_PATTERN_A, 64'h0, 8'h00, 1'b0, 1'b0, 8'h00},
    '{ROW_TEXT, REG_PATTERN_A, 64'h0, 8'h7A, 1'b1, 1'b0, 8'h00},
    // full-length pattern filling the whole chunk
    '{ROW_TEXT, REG_PATTERN_A, 64'h0, 8'h7A, 1'b0, 1'b0, 8'h00},
    '{ROW_TEXT, REG_PATTERN_A, 64'h0, 8'h7A, 1'b0, 1'b0, 8'h00},
    '{ROW_TEXT, REG_PATTERN_A, 64'h0, 8'h7A, 1'b0, 1'b0, 8'h00},
    '{ROW_TEXT, REG_PATTERN_A, 64'h0, 8'h7A, 1'b0, 1'b0, 8'h00},
    '{ROW_TEXT, REG_PATTERN_A, 64'h0, 8'h7A, 1'b0, 1'b0, 8'h00},
    '{ROW_TEXT, REG_PATTERN_A, 64'h0, 8'h7A, 1'b0, 1'b0, 8'h00},
    '{ROW_TEXT, REG_PATTERN_A, 64'h0, 8'h7A, 1'b0, 1'b0, 8'h00},
    '{ROW_TEXT, REG_PATTERN_A, 64'h0, 8'h7A, 1'b1, 1'b0, 8'h00},
    // "ba" then chunk end: a match would run past the end, so nothing is starred
    '{ROW_TEXT, REG_PATTERN_A, 64'h0, 8'h62, 1'b0, 1'b0, 8'h00},
    '{ROW_TEXT, REG_PATTERN_A, 64'h0, 8'h61, 1'b1, 1'b0, 8'h00}
  };

  // Model state: register copies plus the bytes each stage holds back.
  logic [63:0] pattern_reg [NUM_SLOTS];
  logic [15:0] lengths_reg;
  logic [7:0]  held_bytes  [NUM_SLOTS][MAX_LEN];
  int unsigned held_cnt    [NUM_SLOTS];
  logic [7:0]  chain_src_q [$];
  logic [7:0]  chain_dst_q [$];
  out_t        masked_bytes_q [$];   // words the block still owes, oldest first

  int unsigned cycle_cnt    = 0;
  int unsigned mismatch_cnt = 0;
  int unsigned checked_cnt  = 0;
  int unsigned bytes_sent;
  int unsigned random_sent;
  int unsigned chunk_cnt;
  int unsigned settings_cnt;
  int unsigned in_stall_cnt;
  bit          gaps_on;
  bit          hold_req;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) cycle_cnt <= cycle_cnt + 1;

  // Watchdog: end the run if the block stops moving words.
  initial begin
    wait (cycle_cnt >= RUN_LIMIT);
    $display("timeout after %0d cycles, %0d words still expected",
             cycle_cnt, masked_bytes_q.size());
    $display("== FAIL ==");
    $finish;
  end

  // Effective length of a stage: nibbles above eight count as eight.
  function automatic int unsigned stage_len(int s);
    int unsigned v;
    v = 32'(lengths_reg[4*s +: 4]);
    return (v > MAX_LEN) ? MAX_LEN : v;
  endfunction

  function automatic logic [7:0] pattern_byte(int s, int unsigned j);
    return pattern_reg[s][8*j +: 8];
  endfunction

  // Emit the oldest byte a stage holds into the next stage's input list.
  function automatic void shift_oldest(int s);
    chain_dst_q.push_back(held_bytes[s][0]);
    for (int j = 0; j < MAX_LEN - 1; j++) held_bytes[s][j] = held_bytes[s][j+1];
    held_bytes[s][MAX_LEN-1] = 8'h00;
    held_cnt[s]--;
  endfunction

  // Push one accepted word through every stage; the bytes that leave the
  // last stage end up in chain_src_q.
  function automatic void run_stage_chain(in_t w);
    int unsigned len;
    int unsigned keep;
    bit          hit;
    chain_src_q.delete();
    chain_src_q.push_back(w.text_byte);
    for (int s = 0; s < NUM_SLOTS; s++) begin
      len  = stage_len(s);
      keep = (len > 0) ? len - 1 : 0;
      chain_dst_q.delete();
      foreach (chain_src_q[k]) begin
        if (held_cnt[s] > MAX_LEN - 1) held_cnt[s] = MAX_LEN - 1;
        held_bytes[s][held_cnt[s]] = chain_src_q[k];
        held_cnt[s]++;
        // test the oldest start position once the window is full, then emit it
        while (held_cnt[s] > keep) begin
          if (len > 0 && held_cnt[s] >= len) begin
            hit = 1'b1;
            for (int unsigned j = 0; j < len; j++)
              if (pattern_byte(s, j) != WILD_CHAR && held_bytes[s][j] != pattern_byte(s, j))
                hit = 1'b0;
            if (hit)
              for (int unsigned j = 0; j < len; j++)
                if (pattern_byte(s, j) != WILD_CHAR) held_bytes[s][j] = MASK_CHAR;
          end
          shift_oldest(s);
        end
      end
      // chunk end: flush the tail unchanged
      if (w.chunk_end) while (held_cnt[s] > 0) shift_oldest(s);
      chain_src_q = chain_dst_q;
    end
  endfunction

  function automatic void flag_error(string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= 10) $display("mismatch: %s", msg);
  endfunction

  // Offer one text word, hold it until accepted, then log what it must produce.
  task automatic send_text(logic [7:0] text, logic last, logic typed, logic [7:0] want);
    in_t         w;
    int unsigned n;
    w.text_byte = text;
    w.chunk_end = last;
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(1, 6)) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    do begin
      @(posedge clk_i);
      if (in_stall_o) in_stall_cnt++;
    end while (in_stall_o);
    run_stage_chain(w);
    n = (chain_src_q.size() > MAX_RESULTS) ? MAX_RESULTS : chain_src_q.size();
    if (typed)
      masked_bytes_q.push_back('{out_byte: want, out_last: last});
    else
      for (int k = 0; k < n; k++)
        masked_bytes_q.push_back('{out_byte: chain_src_q[k], out_last: last && k == n - 1});
    bytes_sent++;
  endtask

  // Drop valid, wait for every owed word, then let the pipeline settle.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (masked_bytes_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // Write one register; keep cfg_valid_i high when another write follows.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] data, bit close);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (close) cfg_valid_i <= 1'b0;
    if (idx < REG_LENGTHS) pattern_reg[idx] = data;
    else if (idx == REG_LENGTHS) lengths_reg = data[15:0];
  endtask

  task automatic load_settings(int kind);
    logic [63:0] pats [NUM_SLOTS];
    logic [15:0] lens;
    case (kind)
      SET_ALL_ONES: begin
        foreach (pats[s]) pats[s] = '1;
        lens = 16'h8888;
      end
      SET_ZERO_LONG: begin
        foreach (pats[s]) pats[s] = '0;
        lens = 16'hFFFF;
      end
      default: begin
        // draw pattern bytes from a small alphabet so matches and overlaps happen
        foreach (pats[s])
          for (int j = 0; j < MAX_LEN; j++)
            case ($urandom_range(0, 5))
              0:       pats[s][8*j +: 8] = 8'h61;   // 'a'
              1:       pats[s][8*j +: 8] = 8'h62;   // 'b'
              2:       pats[s][8*j +: 8] = MASK_CHAR;
              3:       pats[s][8*j +: 8] = WILD_CHAR;
              4:       pats[s][8*j +: 8] = 8'h00;
              default: pats[s][8*j +: 8] = 8'($urandom);
            endcase
        if (kind == SET_EMPTY) lens = '0;
        else if ($urandom_range(0, 3) == 0) lens = 16'($urandom);
        else
          for (int s = 0; s < NUM_SLOTS; s++) lens[4*s +: 4] = 4'($urandom_range(0, MAX_LEN));
      end
    endcase
    wait_idle();
    // an index past the last register must be ignored
    if ($urandom_range(0, 2) == 0)
      write_reg(CFG_IDX_W'($urandom_range(FIRST_UNUSED_REG, (1 << CFG_IDX_W) - 1)),
                {$urandom, $urandom}, 1'b0);
    for (int s = 0; s < NUM_SLOTS; s++)
      write_reg(CFG_IDX_W'(int'(REG_PATTERN_A) + s), pats[s], 1'b0);
    write_reg(REG_LENGTHS, {48'h0, lens}, 1'b1);
    settings_cnt++;
  endtask

  // Build one chunk mostly from pattern copies, stars and pattern bytes,
  // with plain random bytes as noise, and send it with its end flag.
  task automatic send_chunk();
    logic [7:0]  text_q [$];
    logic [7:0]  pb;
    int unsigned want_len;
    int unsigned s;
    want_len = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 50) : $urandom_range(1, 16);
    while (text_q.size() < want_len) begin
      case ($urandom_range(0, 3))
        0: begin
          s = $urandom_range(0, NUM_SLOTS - 1);
          for (int unsigned j = 0; j < stage_len(s); j++) begin
            pb = pattern_byte(s, j);
            text_q.push_back((pb == WILD_CHAR) ? 8'($urandom) : pb);
          end
        end
        1:       text_q.push_back(MASK_CHAR);
        2:       text_q.push_back(pattern_byte($urandom_range(0, NUM_SLOTS - 1),
                                               $urandom_range(0, MAX_LEN - 1)));
        default: text_q.push_back(8'($urandom));
      endcase
    end
    foreach (text_q[k]) begin
      send_text(text_q[k], k == text_q.size() - 1, 1'b0, 8'h00);
      random_sent++;
    end
    chunk_cnt++;
  endtask

  // Receiver: check every accepted word, stall in short bursts, and take
  // one long hold when asked so the block backs up to its input.
  initial begin
    out_t        want;
    int unsigned hold_left;
    bit          hold_taken;
    hold_left   = 0;
    hold_taken  = 1'b0;
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        if (masked_bytes_q.size() == 0)
          flag_error($sformatf("unexpected word %02h last %0b",
                               out_word_o.out_byte, out_word_o.out_last));
        else begin
          want = masked_bytes_q.pop_front();
          checked_cnt++;
          if (out_word_o.out_byte !== want.out_byte)
            flag_error($sformatf("word %0d byte: expected %02h, got %02h",
                                 checked_cnt, want.out_byte, out_word_o.out_byte));
          if (out_word_o.out_last !== want.out_last)
            flag_error($sformatf("word %0d last: expected %0b, got %0b",
                                 checked_cnt, want.out_last, out_word_o.out_last));
        end
      end
      if (hold_req && !hold_taken) begin
        hold_left  = LONG_HOLD;
        hold_taken = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (gaps_on && $urandom_range(0, 9) == 0) begin
        hold_left   = $urandom_range(0, 5);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Main flow: reset, directed table, random phases, drain, verdict.
  initial begin
    int unsigned phase;
    int unsigned phase_goal;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    in_word_i    = '0;
    cfg_valid_i  = 1'b0;
    cfg_index_i  = REG_PATTERN_A;
    cfg_data_i   = '0;
    bytes_sent   = 0;
    random_sent  = 0;
    chunk_cnt    = 0;
    settings_cnt = 0;
    in_stall_cnt = 0;
    gaps_on      = 1'b1;
    hold_req     = 1'b0;
    lengths_reg  = '0;
    for (int s = 0; s < NUM_SLOTS; s++) begin
      pattern_reg[s] = '0;
      held_cnt[s]    = 0;
      for (int j = 0; j < MAX_LEN; j++) held_bytes[s][j] = 8'h00;
    end

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Walk the table; a run of config rows forms one write burst on an idle block.
    for (int r = 0; r < PLAN_ROWS; r++) begin
      if (plan_tbl[r].is_cfg) begin
        if (r == 0 || !plan_tbl[r-1].is_cfg) wait_idle();
        write_reg(plan_tbl[r].reg_sel, plan_tbl[r].value,
                  r == PLAN_ROWS - 1 || !plan_tbl[r+1].is_cfg);
      end else begin
        send_text(plan_tbl[r].text, plan_tbl[r].last, plan_tbl[r].typed, plan_tbl[r].want);
        if (plan_tbl[r].last) chunk_cnt++;
      end
    end

    // Random phases: new settings, then whole chunks until the phase quota is met.
    phase = 0;
    while (random_sent < RANDOM_ITEMS) begin
      phase++;
      load_settings((phase < HOLD_PHASE) ? int'(phase) : 0);
      if (random_sent > RANDOM_ITEMS * 85 / 100) gaps_on = 1'b0;
      if (phase == HOLD_PHASE) hold_req = 1'b1;
      phase_goal = random_sent + ((phase == HOLD_PHASE) ? 80 : 32);
      while (random_sent < phase_goal && random_sent < RANDOM_ITEMS) begin
        send_chunk();
        if (random_sent > RANDOM_ITEMS * 85 / 100) gaps_on = 1'b0;
      end
    end

    wait_idle();
    $display("sent %0d text bytes in %0d chunks under %0d pattern settings",
             bytes_sent, chunk_cnt, settings_cnt + 1);
    $display("checked %0d output words, input held off %0d cycles, %0d mismatches",
             checked_cnt, in_stall_cnt, mismatch_cnt);
    if (mismatch_cnt == 0 && masked_bytes_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
